@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scan driver RTL.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define SSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define SSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ssd_pkg.sv @@
// Types, codes and decode tables for the seven-segment scan driver.
// Used by ssd_digit_pipe and seven_segment_scan_driver; depends on nothing.
package ssd_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_POINT = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [7:0] GLYPH_POINT = 8'h80;
    localparam logic [7:0] GLYPH_BLANK = 8'h00;

    // Reciprocal of ten, exact for any 16-bit dividend with a shift of 19.
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_TEN_SH = 19;

    // One word moving down the digit pipeline.
    typedef struct packed {
        logic        tick;        // word is a scan tick
        logic        show_digit;  // digit phase, else point-only phase
        logic        dp_lit;      // point bit of the scanned position
        logic [2:0]  pos;         // scanned position
        logic [15:0] value;       // stored display number after this word
    } ssd_item_t;

    typedef struct packed {
        ssd_item_t  item;
        logic [3:0] digit;
    } ssd_result_t;

    // value / 10^k == (value * recip_mult(k)) >> recip_shift(k) for 16-bit value.
    // Positions past the fifth digit get zero, which yields a zero digit.
    function automatic logic [16:0] recip_mult(input logic [2:0] k);
        logic [16:0] m;
        unique case (k)
            3'd0:    m = 17'd1;
            3'd1:    m = 17'd52429;
            3'd2:    m = 17'd83887;
            3'd3:    m = 17'd67109;
            3'd4:    m = 17'd107375;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] recip_shift(input logic [2:0] k);
        logic [4:0] s;
        unique case (k)
            3'd0:    s = 5'd0;
            3'd1:    s = 5'd19;
            3'd2:    s = 5'd23;
            3'd3:    s = 5'd26;
            3'd4:    s = 5'd30;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Active-high segment pattern, bit0 A .. bit6 G.
    function automatic logic [7:0] glyph_digit(input logic [3:0] d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/ssd_digit_pipe.sv @@
// Two-stage decimal digit extraction: value / 10^pos by reciprocal multiply,
// then the remainder by ten. Depends on ssd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssd_digit_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssd_pkg::ssd_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssd_pkg::ssd_result_t out_res
);
    import ssd_pkg::*;

    logic        a_valid_reg;
    ssd_item_t   a_item_reg;
    logic [32:0] a_prod_reg;
    logic [32:0] a_prod_next;

    logic        b_valid_reg;
    ssd_item_t   b_item_reg;
    logic [15:0] b_quot_reg;
    logic [31:0] b_prod_reg;
    logic [15:0] b_quot_next;
    logic [31:0] b_prod_next;

    logic        a_ready;
    logic        b_ready;
    logic [12:0] tens;
    logic [15:0] rem;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_prod_next = {1'b0, in_item.value} * {16'd0, recip_mult(in_item.pos)};

    always_comb
    begin
        b_quot_next = 16'(a_prod_reg >> recip_shift(a_item_reg.pos));
        b_prod_next = b_quot_next * RECIP_TEN;
    end

    // remainder = q - 10 * floor(q / 10)
    assign tens = b_prod_reg[31:RECIP_TEN_SH];
    assign rem  = b_quot_reg - ((16'(tens) << 3) + (16'(tens) << 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg <= in_item;
            a_prod_reg <= a_prod_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg <= a_item_reg;
            b_quot_reg <= b_quot_next;
            b_prod_reg <= b_prod_next;
        end
    end

    assign out_valid     = b_valid_reg;
    assign out_res.item  = b_item_reg;
    assign out_res.digit = rem[3:0];

    `SSD_ASSERT_IMPL(a_digit_range, b_valid_reg, rem <= 16'd9, "digit remainder above nine")
    `SSD_ASSERT_NEXT(a_stage_hold, a_valid_reg && !b_ready, a_valid_reg, "stage A word dropped")
endmodule

@@ rtl/seven_segment_scan_driver.sv @@
// Top level of the four-digit multiplexed seven-segment scan driver.
// Depends on ssd_pkg, ssd_digit_pipe and assert_macros.svh.
//
// Takes one word per clock cycle while in_stall is low and returns one result
// per word. On its way to the result a word passes the input register, the two
// stages of the decimal digit extraction in ssd_digit_pipe (a reciprocal
// multiply for value / 10^pos, then a second multiply for the remainder by ten)
// and the output register. An output stall holds a full output register, and
// each stage holds only once every register after it is full; the input stalls
// only once all four registers are full. The display value, point bits and scan
// phase are updated at acceptance; the segment and enable drives are updated at
// the output register and held across non-tick words.
`include "assert_macros.svh"

module seven_segment_scan_driver #(
    parameter int POSITIONS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] value,
    input  logic [3:0]  dp_mask,
    input  logic        dp_on,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  segments_n,
    output logic [3:0]  digit_enable,
    output logic [15:0] shown_value
);
    import ssd_pkg::*;

    localparam int PHASES  = 2 * POSITIONS;
    localparam int PHASE_W = (PHASES > 2) ? $clog2(PHASES) : 1;
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASES - 1);
    localparam logic [PHASE_W-1:0] POS_COUNT  = PHASE_W'(POSITIONS);

    logic [15:0]          value_reg;
    logic [15:0]          value_next;
    logic [POSITIONS-1:0] points_reg;
    logic [POSITIONS-1:0] points_next;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;

    logic                 s1_valid_reg;
    ssd_item_t            s1_item_reg;
    ssd_item_t            s1_item_next;

    logic [7:0]           seg_reg;
    logic [3:0]           en_reg;
    logic [15:0]          shown_reg;
    logic                 out_valid_reg;

    logic                 in_acc;
    logic                 s1_ready;
    logic                 pipe_ready;
    logic                 pipe_valid;
    logic                 out_ready;
    ssd_result_t          pipe_res;
    func_t                func_code;
    logic [7:0]           mask_wide;
    logic [POSITIONS-1:0] mask_eff;
    logic [POSITIONS-1:0] points_sel;
    logic [PHASE_W-1:0]   pos_full;
    logic [7:0]           glyph;

    assign func_code = func_t'(func);
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || pipe_ready;
    assign in_stall  = !s1_ready;
    assign in_acc    = in_valid && s1_ready;

    assign mask_wide = {4'd0, dp_mask};
    assign mask_eff  = mask_wide[POSITIONS-1:0];

    // state update at acceptance
    always_comb
    begin
        value_next  = value_reg;
        points_next = points_reg;
        phase_next  = phase_reg;
        unique case (func_code)
            FUNC_TICK:  phase_next = (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
            FUNC_WRITE: value_next = value;
            FUNC_POINT: points_next = dp_on ? (points_reg | mask_eff) : (points_reg & ~mask_eff);
            default:    ;
        endcase
    end

    always_comb
    begin
        pos_full   = (phase_next < POS_COUNT) ? phase_next : phase_next - POS_COUNT;
        points_sel = points_next >> pos_full;
        s1_item_next.tick       = (func_code == FUNC_TICK);
        s1_item_next.show_digit = (phase_next < POS_COUNT);
        s1_item_next.dp_lit     = points_sel[0];
        s1_item_next.pos        = 3'(pos_full);
        s1_item_next.value      = value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= '0;
            points_reg    <= '0;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            seg_reg       <= 8'hFF;
            en_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                value_reg  <= value_next;
                points_reg <= points_next;
                phase_reg  <= phase_next;
            end
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (out_ready)
                out_valid_reg <= pipe_valid;
            if (out_ready && pipe_valid && pipe_res.item.tick)
            begin
                seg_reg <= ~glyph;
                en_reg  <= pipe_res.item.pos[2] ? 4'd0 : (4'b0001 << pipe_res.item.pos[1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_item_reg <= s1_item_next;
        if (out_ready && pipe_valid)
            shown_reg <= pipe_res.item.value;
    end

    ssd_digit_pipe u_digit_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (pipe_ready),
        .in_item   (s1_item_reg),
        .out_valid (pipe_valid),
        .out_ready (out_ready),
        .out_res   (pipe_res)
    );

    always_comb
    begin
        if (pipe_res.item.show_digit)
            glyph = glyph_digit(pipe_res.digit);
        else if (pipe_res.item.dp_lit)
            glyph = GLYPH_POINT;
        else
            glyph = GLYPH_BLANK;
    end

    assign out_valid    = out_valid_reg;
    assign segments_n   = seg_reg;
    assign digit_enable = en_reg;
    assign shown_value  = shown_reg;

    `SSD_ASSERT(a_enable_onehot, $onehot0(en_reg), "more than one position enabled")
    `SSD_ASSERT_NEXT(a_tick_moves, in_acc && func_code == FUNC_TICK, phase_reg != $past(phase_reg), "tick did not advance phase")
    `SSD_ASSERT_NEXT(a_other_holds, in_acc && func_code != FUNC_TICK, $stable(phase_reg), "phase moved without tick")
    `SSD_ASSERT_NEXT(a_write_value, in_acc && func_code == FUNC_WRITE, value_reg == $past(value), "display value not stored")
endmodule
